// ===== sv/i2cbm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types, codes and the micro-sequence table of the I2C bit-level master.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

  localparam int unsigned StepW  = 6;
  localparam int unsigned OpW    = 5;
  localparam logic [StepW-1:0] StepIdle = 6'd63;
  localparam logic [StepW-1:0] RomLen   = 6'd62;
  localparam logic [7:0] MsbMask        = 8'h80;
  localparam logic [3:0] ResetClocks    = 4'd9;
  localparam logic [3:0] ByteBits       = 4'd8;
  localparam logic [7:0] HalfPeriodRst  = 8'd9;
  localparam logic [7:0] StretchRst     = 8'd20;

  // configuration register indexes
  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_HALF    = 2'd1;
  localparam logic [1:0] REG_STRETCH = 2'd2;

  // command opcodes
  localparam logic [3:0] CMD_NONE  = 4'd0;
  localparam logic [3:0] CMD_START = 4'd1;
  localparam logic [3:0] CMD_STOP  = 4'd2;
  localparam logic [3:0] CMD_ACK   = 4'd3;
  localparam logic [3:0] CMD_NACK  = 4'd4;
  localparam logic [3:0] CMD_SEND  = 4'd5;
  localparam logic [3:0] CMD_READ  = 4'd6;
  localparam logic [3:0] CMD_RACK  = 4'd7;
  localparam logic [3:0] CMD_RESET = 4'd8;
  localparam logic [3:0] CMD_PROBE = 4'd9;

  // status codes
  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_NACK    = 3'd1;
  localparam logic [2:0] STS_MODE    = 3'd2;
  localparam logic [2:0] STS_LOST    = 3'd3;
  localparam logic [2:0] STS_TIMEOUT = 3'd4;

  // micro-operations
  localparam logic [OpW-1:0] U_SCL0      = 5'd0;
  localparam logic [OpW-1:0] U_SCL1      = 5'd1;
  localparam logic [OpW-1:0] U_SDA0      = 5'd2;
  localparam logic [OpW-1:0] U_SDA1      = 5'd3;
  localparam logic [OpW-1:0] U_SDABIT    = 5'd4;
  localparam logic [OpW-1:0] U_CHK       = 5'd5;
  localparam logic [OpW-1:0] U_DLY       = 5'd6;
  localparam logic [OpW-1:0] U_SHIFTIN   = 5'd7;
  localparam logic [OpW-1:0] U_LOOPSEND  = 5'd8;
  localparam logic [OpW-1:0] U_LOOP8     = 5'd9;
  localparam logic [OpW-1:0] U_LOOP9     = 5'd10;
  localparam logic [OpW-1:0] U_STRETCH   = 5'd11;
  localparam logic [OpW-1:0] U_END_START = 5'd12;
  localparam logic [OpW-1:0] U_END_STOP  = 5'd13;
  localparam logic [OpW-1:0] U_END_SEND  = 5'd14;
  localparam logic [OpW-1:0] U_END_READ  = 5'd15;
  localparam logic [OpW-1:0] U_END_RACK  = 5'd16;
  localparam logic [OpW-1:0] U_END       = 5'd17;

  // sequence entry points
  localparam logic [StepW-1:0] E_START = 6'd0;
  localparam logic [StepW-1:0] E_STOP  = 6'd10;
  localparam logic [StepW-1:0] E_BIT   = 6'd17;
  localparam logic [StepW-1:0] E_SEND  = 6'd28;
  localparam logic [StepW-1:0] E_READ  = 6'd40;
  localparam logic [StepW-1:0] E_RACK  = 6'd48;
  localparam logic [StepW-1:0] E_RESET = 6'd55;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [StepW-1:0] target;
  } micro_t;

  typedef struct packed {
    logic       sda_level;
    logic       scl_level;
    logic [7:0] cmd_byte;
    logic [3:0] opcode;
  } item_t;

  typedef struct packed {
    logic       master_enable;
    logic [7:0] half_period_ticks;
    logic [7:0] stretch_limit;
  } cfg_t;

  typedef struct packed {
    logic [StepW-1:0] step;
    logic [3:0]       cmd;
    logic [7:0]       shift;
    logic [3:0]       bit_cnt;
    logic [7:0]       dly_cnt;
    logic [7:0]       str_cnt;
    logic             scl;
    logic             sda;
    logic [7:0]       rd;
    logic             ack;
  } seq_t;

  // first member sits in the top bits, so scl_drive lands in bit 0
  typedef struct packed {
    logic [7:0] read_byte;
    logic [2:0] status;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       scl_drive;
  } res_t;

  function automatic micro_t rom_rd(input logic [StepW-1:0] idx);
    micro_t m;
    m = '{op: U_END, target: '0};
    case (idx)
      // start
      6'd0:  m.op = U_SDA1;
      6'd1:  m.op = U_CHK;
      6'd2:  m.op = U_SCL1;
      6'd3:  m.op = U_DLY;
      6'd4:  m.op = U_SDA0;
      6'd5:  m.op = U_DLY;
      6'd6:  m.op = U_CHK;
      6'd7:  m.op = U_SCL0;
      6'd8:  m.op = U_DLY;
      6'd9:  m.op = U_END_START;
      // stop
      6'd10: m.op = U_SDA0;
      6'd11: m.op = U_CHK;
      6'd12: m.op = U_SCL1;
      6'd13: m.op = U_DLY;
      6'd14: m.op = U_SDA1;
      6'd15: m.op = U_CHK;
      6'd16: m.op = U_END_STOP;
      // ack / nack
      6'd17: m.op = U_SCL0;
      6'd18: m.op = U_DLY;
      6'd19: m.op = U_SDABIT;
      6'd20: m.op = U_CHK;
      6'd21: m.op = U_SCL1;
      6'd22: m.op = U_DLY;
      6'd23: m.op = U_SCL0;
      6'd24: m.op = U_DLY;
      6'd25: m.op = U_SDA1;
      6'd26: m.op = U_CHK;
      6'd27: m.op = U_END;
      // send
      6'd28: m.op = U_SCL0;
      6'd29: m.op = U_DLY;
      6'd30: m.op = U_SDABIT;
      6'd31: m.op = U_CHK;
      6'd32: m.op = U_SCL1;
      6'd33: m.op = U_DLY;
      6'd34: m = '{op: U_LOOPSEND, target: E_SEND};
      6'd35: m.op = U_SCL0;
      6'd36: m.op = U_DLY;
      6'd37: m.op = U_SDA1;
      6'd38: m.op = U_CHK;
      6'd39: m.op = U_END_SEND;
      // read
      6'd40: m.op = U_SDA1;
      6'd41: m.op = U_SCL1;
      6'd42: m.op = U_DLY;
      6'd43: m.op = U_SHIFTIN;
      6'd44: m.op = U_SCL0;
      6'd45: m.op = U_DLY;
      6'd46: m = '{op: U_LOOP8, target: E_READ + 6'd1};
      6'd47: m.op = U_END_READ;
      // read ack
      6'd48: m.op = U_SDA1;
      6'd49: m.op = U_SCL1;
      6'd50: m.op = U_DLY;
      6'd51: m.op = U_STRETCH;
      6'd52: m.op = U_SCL0;
      6'd53: m.op = U_DLY;
      6'd54: m.op = U_END_RACK;
      // bus reset
      6'd55: m.op = U_SCL1;
      6'd56: m.op = U_DLY;
      6'd57: m.op = U_SCL0;
      6'd58: m.op = U_DLY;
      6'd59: m = '{op: U_LOOP9, target: E_RESET};
      6'd60: m.op = U_SCL1;
      6'd61: m.op = U_END;
      default: m.op = U_END;
    endcase
    return m;
  endfunction

  function automatic logic [StepW-1:0] entry_of(input logic [3:0] opc);
    logic [StepW-1:0] e;
    case (opc)
      CMD_START, CMD_PROBE: e = E_START;
      CMD_STOP:             e = E_STOP;
      CMD_ACK, CMD_NACK:    e = E_BIT;
      CMD_SEND:             e = E_SEND;
      CMD_READ:             e = E_READ;
      CMD_RACK:             e = E_RACK;
      CMD_RESET:            e = E_RESET;
      default:              e = E_START;
    endcase
    return e;
  endfunction

endpackage

// ===== sv/i2cbm_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_seq
// One tick of the micro-sequencer: next state and the result of the tick.
// ----------------------------------------------------------------------------
module i2cbm_seq (
  input  i2cbm_pkg::seq_t  st_i,
  input  i2cbm_pkg::item_t item_i,
  input  i2cbm_pkg::cfg_t  cfg_i,
  output i2cbm_pkg::seq_t  st_o,
  output i2cbm_pkg::res_t  res_o
);

  i2cbm_pkg::seq_t   nx;
  i2cbm_pkg::micro_t m;
  logic [5:0]        nstep;
  logic              done;
  logic [2:0]        status;
  logic              probe;
  logic [7:0]        hp;
  logic [8:0]        dly_inc;
  logic [3:0]        bit_inc;
  logic [3:0]        lim;

  assign hp      = (cfg_i.half_period_ticks == 8'd0) ? 8'd1 : cfg_i.half_period_ticks;
  assign probe   = (st_i.cmd == i2cbm_pkg::CMD_PROBE);
  assign m       = i2cbm_pkg::rom_rd(st_i.step);
  assign dly_inc = {1'b0, st_i.dly_cnt} + 9'd1;
  assign bit_inc = st_i.bit_cnt + 4'd1;
  assign lim     = (m.op == i2cbm_pkg::U_LOOP9) ? i2cbm_pkg::ResetClocks : i2cbm_pkg::ByteBits;

  always_comb begin
    nx     = st_i;
    nstep  = st_i.step + 6'd1;
    done   = 1'b0;
    status = i2cbm_pkg::STS_OK;
    if (st_i.step >= i2cbm_pkg::RomLen) begin
      nx.step = i2cbm_pkg::StepIdle;
      if (item_i.opcode inside {[i2cbm_pkg::CMD_START : i2cbm_pkg::CMD_PROBE]}) begin
        if (!cfg_i.master_enable) begin
          done   = 1'b1;
          status = i2cbm_pkg::STS_MODE;
        end else begin
          nx.cmd  = item_i.opcode;
          nx.step = i2cbm_pkg::entry_of(item_i.opcode);
          if (item_i.opcode == i2cbm_pkg::CMD_ACK) begin
            nx.shift = 8'd0;
          end else if (item_i.opcode == i2cbm_pkg::CMD_NACK) begin
            nx.shift = i2cbm_pkg::MsbMask;
          end else begin
            nx.shift = item_i.cmd_byte;
          end
          nx.bit_cnt = 4'd0;
          nx.dly_cnt = 8'd0;
          nx.str_cnt = 8'd0;
          nx.ack     = 1'b0;
        end
      end
    end else begin
      case (m.op)
        i2cbm_pkg::U_SCL0:   nx.scl = 1'b0;
        i2cbm_pkg::U_SCL1:   nx.scl = 1'b1;
        i2cbm_pkg::U_SDA0:   nx.sda = 1'b0;
        i2cbm_pkg::U_SDA1:   nx.sda = 1'b1;
        i2cbm_pkg::U_SDABIT: nx.sda = st_i.shift[7];
        i2cbm_pkg::U_CHK: begin
          if (item_i.sda_level != st_i.sda) begin
            done   = 1'b1;
            status = i2cbm_pkg::STS_LOST;
          end
        end
        i2cbm_pkg::U_DLY: begin
          if (dly_inc >= {1'b0, hp}) begin
            nx.dly_cnt = 8'd0;
          end else begin
            nx.dly_cnt = dly_inc[7:0];
            nstep      = st_i.step;
          end
        end
        i2cbm_pkg::U_SHIFTIN: nx.shift = {st_i.shift[6:0], item_i.sda_level};
        i2cbm_pkg::U_LOOPSEND, i2cbm_pkg::U_LOOP8, i2cbm_pkg::U_LOOP9: begin
          if (m.op == i2cbm_pkg::U_LOOPSEND) begin
            nx.shift = {st_i.shift[6:0], 1'b0};
          end
          if (bit_inc < lim) begin
            nx.bit_cnt = bit_inc;
            nstep      = m.target;
          end else begin
            nx.bit_cnt = 4'd0;
          end
        end
        i2cbm_pkg::U_STRETCH: begin
          nstep = st_i.step;
          if (st_i.dly_cnt != 8'd0) begin
            nx.dly_cnt = (dly_inc >= {1'b0, hp}) ? 8'd0 : dly_inc[7:0];
          end else if (item_i.scl_level) begin
            nx.ack = item_i.sda_level;
            nstep  = st_i.step + 6'd1;
          end else if (st_i.str_cnt >= cfg_i.stretch_limit) begin
            done   = 1'b1;
            status = i2cbm_pkg::STS_TIMEOUT;
          end else begin
            // each low check buys one more settling delay
            nx.str_cnt = st_i.str_cnt + 8'd1;
            nx.dly_cnt = (hp <= 8'd1) ? 8'd0 : 8'd1;
          end
        end
        i2cbm_pkg::U_END_START: begin
          if (probe) nstep = i2cbm_pkg::E_SEND;
          else done = 1'b1;
        end
        i2cbm_pkg::U_END_SEND: begin
          if (probe) nstep = i2cbm_pkg::E_RACK;
          else done = 1'b1;
        end
        i2cbm_pkg::U_END_RACK: begin
          if (probe) begin
            nstep = i2cbm_pkg::E_STOP;
          end else begin
            done   = 1'b1;
            status = {2'b00, st_i.ack};
          end
        end
        i2cbm_pkg::U_END_STOP: begin
          done   = 1'b1;
          status = probe ? {2'b00, st_i.ack} : i2cbm_pkg::STS_OK;
        end
        i2cbm_pkg::U_END_READ: begin
          nx.rd = st_i.shift;
          done  = 1'b1;
        end
        default: done = 1'b1;
      endcase
      nx.step = done ? i2cbm_pkg::StepIdle : nstep;
    end
  end

  assign st_o             = nx;
  assign res_o.scl_drive  = nx.scl;
  assign res_o.sda_drive  = nx.sda;
  assign res_o.busy_res   = (nx.step < i2cbm_pkg::RomLen);
  assign res_o.done_res   = done;
  assign res_o.status     = status;
  assign res_o.read_byte  = nx.rd;

endmodule

// ===== sv/i2cbm_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_obuf
// Result register between the sequencer and the master-side stream.
// ----------------------------------------------------------------------------
module i2cbm_obuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  i2cbm_pkg::res_t res_i,
  output logic            valid_o,
  input  logic            ready_i,
  output i2cbm_pkg::res_t res_o
);

  logic            valid_q, valid_d;
  i2cbm_pkg::res_t res_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== sv/i2c_bit_level_master.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// I2C master sequencer, one timing tick per stream request.
// ----------------------------------------------------------------------------
// Usage: each slave-side request is one prescaled tick carrying the sampled
// SCL/SDA levels and, while idle, a command opcode with its byte. Each tick
// yields exactly one master-side request with the pin drives, busy, done,
// status and the last read byte, in the order the ticks arrived.
// The cfg channel writes master_enable, half_period_ticks and stretch_limit
// by index; it is always ready. It is to be written by the user only while
// the block is idle; the block itself does not enforce that.
// A tick enters an input register, is processed by the combinational
// sequencer and its result is captured in the output register, which raises
// tvalid. Throughput is one tick per cycle while the receiver does not stall.
// When the receiver stalls the output register holds its result and the
// input register fills; s_axis_tready then drops until the result leaves.
// Reset leaves both pins released, the sequencer idle, master mode off,
// half period 9 and stretch limit 20.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[3:0], cmd_byte[11:4], scl_level[12], sda_level[13], zero[15:14]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_drive[0], sda_drive[1], busy_res[2], done_res[3], status[6:4],
  // read_byte[14:7], zero[15]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic             in_valid_q;
  i2cbm_pkg::item_t in_item_q;
  logic             adv;
  logic             ob_ready;
  i2cbm_pkg::cfg_t  cfg_q;
  i2cbm_pkg::seq_t  st_q, st_d;
  i2cbm_pkg::res_t  res_d, res_out;

  assign cfg_ready_o   = 1'b1;
  assign adv           = in_valid_q && ob_ready;
  assign s_axis_tready = !in_valid_q || ob_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.master_enable     <= 1'b0;
      cfg_q.half_period_ticks <= i2cbm_pkg::HalfPeriodRst;
      cfg_q.stretch_limit     <= i2cbm_pkg::StretchRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        i2cbm_pkg::REG_ENABLE:  cfg_q.master_enable     <= cfg_data_i[0];
        i2cbm_pkg::REG_HALF:    cfg_q.half_period_ticks <= cfg_data_i;
        i2cbm_pkg::REG_STRETCH: cfg_q.stretch_limit     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= s_axis_tdata[13:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{step: i2cbm_pkg::StepIdle, scl: 1'b1, sda: 1'b1, default: '0};
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  i2cbm_seq u_seq (
    .st_i   (st_q),
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  i2cbm_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .ready_o (ob_ready),
    .res_i   (res_d),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {1'b0, res_out};

`ifndef SYNTH
  // a finished command leaves the sequencer idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_out.done_res |-> !res_out.busy_res)
    else $error("done reported while busy");

  // status is only meaningful on a done tick
  a_status_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_out.done_res |-> res_out.status == i2cbm_pkg::STS_OK)
    else $error("status set without done");

  // loop counter never passes the bus reset clock count
  a_bit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.bit_cnt <= i2cbm_pkg::ResetClocks)
    else $error("bit counter out of range");

  // state moves only when a request is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(st_q))
    else $error("sequencer state changed without a request");
`endif

endmodule

// ===== tb/i2c_bit_level_master_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_tb
// Tick-by-tick check of the I2C bit-level master against a behavioral copy.
// ----------------------------------------------------------------------------
// The stimulus is built per command: each tick is predicted as it is queued,
// so the emulated bus can answer each drive the way a well-behaved slave
// would (readback, read data, ack, clock stretching), with some ticks broken
// on purpose. Every result is compared field by field in tick order. The
// configuration is swept between phases while the master is idle.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_tb;

  localparam int StallLimit = 5000;
  localparam int HoldOff    = 400;
  localparam int CalmFrom   = 900;
  localparam int CalmTo     = 1300;

  // one step of a command sequence
  typedef enum logic [4:0] {
    M_SCL_LO, M_SCL_HI, M_SDA_LO, M_SDA_HI, M_SDA_BIT, M_CHECK, M_WAIT,
    M_SAMPLE, M_NEXT_TX, M_NEXT_RX, M_NEXT_CLK, M_STRETCH, M_FIN_START,
    M_FIN_STOP, M_FIN_TX, M_FIN_RX, M_FIN_RACK, M_FIN
  } mop_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [7:0]  cfg_data_i    = '0;

  // configuration as the master sees it
  logic       c_en   = 1'b0;
  logic [7:0] c_half = i2cbm_pkg::HalfPeriodRst;
  logic [7:0] c_lim  = i2cbm_pkg::StretchRst;

  // sequencer state of the behavioral copy
  logic [5:0] p_step  = i2cbm_pkg::StepIdle;
  logic [3:0] p_cmd   = i2cbm_pkg::CMD_NONE;
  logic [7:0] p_shift = '0;
  logic [3:0] p_bits  = '0;
  logic [7:0] p_dly   = '0;
  logic [7:0] p_strc  = '0;
  logic       p_scl   = 1'b1;
  logic       p_sda   = 1'b1;
  logic [7:0] p_rd    = '0;
  logic       p_ack   = 1'b0;

  i2cbm_pkg::item_t tick_q[$];
  i2cbm_pkg::res_t  bus_status_q[$];

  int   cyc        = 0;
  int   stall_cnt  = 0;
  int   hold_cnt   = 0;
  bit   hold_done  = 1'b0;
  int   ticks_seen = 0;
  int   mismatches = 0;
  int   status_hits[0:7];
  i2cbm_pkg::res_t got_res;
  i2cbm_pkg::res_t want_res;
  logic calm;

  assign calm = (cyc >= CalmFrom) && (cyc < CalmTo);

  i2c_bit_level_master i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic mop_e step_op(input logic [5:0] s);
    mop_e o;
    case (s)
      6'd7, 6'd17, 6'd23, 6'd28, 6'd35, 6'd44, 6'd52, 6'd57: o = M_SCL_LO;
      6'd2, 6'd12, 6'd21, 6'd32, 6'd41, 6'd49, 6'd55, 6'd60: o = M_SCL_HI;
      6'd4, 6'd10: o = M_SDA_LO;
      6'd0, 6'd14, 6'd25, 6'd37, 6'd40, 6'd48: o = M_SDA_HI;
      6'd19, 6'd30: o = M_SDA_BIT;
      6'd1, 6'd6, 6'd11, 6'd15, 6'd20, 6'd26, 6'd31, 6'd38: o = M_CHECK;
      6'd3, 6'd5, 6'd8, 6'd13, 6'd18, 6'd22, 6'd24, 6'd29, 6'd33, 6'd36,
      6'd42, 6'd45, 6'd50, 6'd53, 6'd56, 6'd58: o = M_WAIT;
      6'd43: o = M_SAMPLE;
      6'd34: o = M_NEXT_TX;
      6'd46: o = M_NEXT_RX;
      6'd59: o = M_NEXT_CLK;
      6'd51: o = M_STRETCH;
      6'd9:  o = M_FIN_START;
      6'd16: o = M_FIN_STOP;
      6'd39: o = M_FIN_TX;
      6'd47: o = M_FIN_RX;
      6'd54: o = M_FIN_RACK;
      default: o = M_FIN;
    endcase
    return o;
  endfunction

  // advance the behavioral master by one tick and give the drive it shows
  task automatic advance_master(input i2cbm_pkg::item_t it, output i2cbm_pkg::res_t r);
    logic [7:0] hp;
    logic [5:0] nxt;
    logic       done;
    logic [2:0] sts;
    logic       probe;
    hp    = (c_half == 8'd0) ? 8'd1 : c_half;
    done  = 1'b0;
    sts   = i2cbm_pkg::STS_OK;
    probe = (p_cmd == i2cbm_pkg::CMD_PROBE);
    if (p_step >= i2cbm_pkg::RomLen) begin
      p_step = i2cbm_pkg::StepIdle;
      if (it.opcode >= i2cbm_pkg::CMD_START && it.opcode <= i2cbm_pkg::CMD_PROBE) begin
        if (!c_en) begin
          done = 1'b1;
          sts  = i2cbm_pkg::STS_MODE;
        end else begin
          p_cmd = it.opcode;
          case (it.opcode)
            i2cbm_pkg::CMD_STOP:                     p_step = i2cbm_pkg::E_STOP;
            i2cbm_pkg::CMD_ACK, i2cbm_pkg::CMD_NACK: p_step = i2cbm_pkg::E_BIT;
            i2cbm_pkg::CMD_SEND:                     p_step = i2cbm_pkg::E_SEND;
            i2cbm_pkg::CMD_READ:                     p_step = i2cbm_pkg::E_READ;
            i2cbm_pkg::CMD_RACK:                     p_step = i2cbm_pkg::E_RACK;
            i2cbm_pkg::CMD_RESET:                    p_step = i2cbm_pkg::E_RESET;
            default:                                 p_step = i2cbm_pkg::E_START;
          endcase
          p_shift = (it.opcode == i2cbm_pkg::CMD_ACK) ? 8'h00 :
                    (it.opcode == i2cbm_pkg::CMD_NACK) ? i2cbm_pkg::MsbMask : it.cmd_byte;
          p_bits = '0;
          p_dly  = '0;
          p_strc = '0;
          p_ack  = 1'b0;
        end
      end
    end else begin
      nxt = p_step + 6'd1;
      case (step_op(p_step))
        M_SCL_LO:  p_scl = 1'b0;
        M_SCL_HI:  p_scl = 1'b1;
        M_SDA_LO:  p_sda = 1'b0;
        M_SDA_HI:  p_sda = 1'b1;
        M_SDA_BIT: p_sda = p_shift[7];
        M_CHECK: begin
          if (it.sda_level != p_sda) begin
            done = 1'b1;
            sts  = i2cbm_pkg::STS_LOST;
          end
        end
        M_WAIT: begin
          p_dly = p_dly + 8'd1;
          if (p_dly >= hp) p_dly = '0;
          else nxt = p_step;
        end
        M_SAMPLE: p_shift = {p_shift[6:0], it.sda_level};
        M_NEXT_TX: begin
          p_shift = p_shift << 1;
          p_bits  = p_bits + 4'd1;
          if (p_bits < i2cbm_pkg::ByteBits) nxt = i2cbm_pkg::E_SEND;
          else p_bits = '0;
        end
        M_NEXT_RX: begin
          p_bits = p_bits + 4'd1;
          if (p_bits < i2cbm_pkg::ByteBits) nxt = i2cbm_pkg::E_READ + 6'd1;
          else p_bits = '0;
        end
        M_NEXT_CLK: begin
          p_bits = p_bits + 4'd1;
          if (p_bits < i2cbm_pkg::ResetClocks) nxt = i2cbm_pkg::E_RESET;
          else p_bits = '0;
        end
        M_STRETCH: begin
          // scl is only looked at once the pending delay has run out
          nxt = p_step;
          if (p_dly != 8'd0) begin
            p_dly = p_dly + 8'd1;
            if (p_dly >= hp) p_dly = '0;
          end else if (it.scl_level) begin
            p_ack = it.sda_level;
            nxt   = p_step + 6'd1;
          end else if (p_strc >= c_lim) begin
            done = 1'b1;
            sts  = i2cbm_pkg::STS_TIMEOUT;
          end else begin
            p_strc = p_strc + 8'd1;
            p_dly  = 8'd1;
            if (p_dly >= hp) p_dly = '0;
          end
        end
        M_FIN_START: begin
          if (probe) nxt = i2cbm_pkg::E_SEND;
          else done = 1'b1;
        end
        M_FIN_TX: begin
          if (probe) nxt = i2cbm_pkg::E_RACK;
          else done = 1'b1;
        end
        M_FIN_RACK: begin
          if (probe) begin
            nxt = i2cbm_pkg::E_STOP;
          end else begin
            done = 1'b1;
            sts  = p_ack ? i2cbm_pkg::STS_NACK : i2cbm_pkg::STS_OK;
          end
        end
        M_FIN_STOP: begin
          done = 1'b1;
          sts  = (probe && p_ack) ? i2cbm_pkg::STS_NACK : i2cbm_pkg::STS_OK;
        end
        M_FIN_RX: begin
          p_rd = p_shift;
          done = 1'b1;
        end
        default: done = 1'b1;
      endcase
      p_step = done ? i2cbm_pkg::StepIdle : nxt;
    end
    r.scl_drive = p_scl;
    r.sda_drive = p_sda;
    r.busy_res  = (p_step < i2cbm_pkg::RomLen);
    r.done_res  = done;
    r.status    = sts;
    r.read_byte = p_rd;
  endtask

  // queue one command plus the ticks until the master is idle again; the
  // emulated bus follows the drives unless noisy or told to break at a given readback
  task automatic issue_command(input logic [3:0] opc, input logic [7:0] tx_byte,
                               input logic [7:0] rx_byte, input logic ack_lvl,
                               input int lost_at, input int hold, input bit noisy);
    i2cbm_pkg::item_t it;
    i2cbm_pkg::res_t  r;
    int    checks;
    int    hold_left;
    bit    first;
    mop_e  op;
    checks    = 0;
    hold_left = hold;
    first     = 1'b1;
    do begin
      it.opcode    = first ? opc :
                     ($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 0)) :
                     i2cbm_pkg::CMD_NONE;
      it.cmd_byte  = first ? tx_byte : 8'($urandom);
      it.scl_level = 1'($urandom_range(1, 0));
      it.sda_level = 1'($urandom_range(1, 0));
      if (!noisy && p_step < i2cbm_pkg::RomLen) begin
        op = step_op(p_step);
        if (op == M_CHECK) begin
          it.sda_level = (checks == lost_at) ? ~p_sda : p_sda;
          checks++;
        end else if (op == M_SAMPLE) begin
          it.sda_level = rx_byte[7 - p_bits];
        end else if (op == M_STRETCH && p_dly == 8'd0) begin
          if (hold_left > 0) begin
            it.scl_level = 1'b0;
            hold_left--;
          end else begin
            it.scl_level = 1'b1;
            it.sda_level = ack_lvl;
          end
        end
      end
      advance_master(it, r);
      tick_q.push_back(it);
      bus_status_q.push_back(r);
      first = 1'b0;
    end while (p_step < i2cbm_pkg::RomLen);
  endtask

  task automatic random_phase(input int n);
    int r;
    int hold;
    for (int i = 0; i < n; i++) begin
      repeat ($urandom_range(2, 0)) begin
        issue_command($urandom_range(1, 0) ? i2cbm_pkg::CMD_NONE :
                      4'($urandom_range(15, i2cbm_pkg::CMD_PROBE + 1)),
                      8'($urandom), 8'h00, 1'b0, -1, 0, 1'b1);
      end
      r    = $urandom_range(99, 0);
      hold = (r < 70) ? 0 : (r < 92) ? $urandom_range(3, 1) : $urandom_range(c_lim + 1, 0);
      if (c_half > 8'd4 && hold > 2) hold = 2;
      issue_command(4'($urandom_range(i2cbm_pkg::CMD_PROBE, i2cbm_pkg::CMD_START)),
                    8'($urandom), 8'($urandom), 1'($urandom_range(1, 0)),
                    ($urandom_range(99, 0) < 5) ? $urandom_range(12, 0) : -1,
                    hold, $urandom_range(99, 0) < 6);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      i2cbm_pkg::REG_ENABLE:  c_en   = val[0];
      i2cbm_pkg::REG_HALF:    c_half = val;
      i2cbm_pkg::REG_STRETCH: c_lim  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic en, input logic [7:0] half, input logic [7:0] lim);
    write_reg(i2cbm_pkg::REG_ENABLE, {7'd0, en});
    write_reg(i2cbm_pkg::REG_HALF, half);
    write_reg(i2cbm_pkg::REG_STRETCH, lim);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every queued tick to come back, plus the pipeline latency
  task automatic drain();
    while (tick_q.size() != 0 || bus_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) status_hits[i] = 0;
    // master mode is off after reset
    issue_command(i2cbm_pkg::CMD_START, 8'h00, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_PROBE, 8'hA0, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_PROBE + 4'd3, 8'hFF, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_NONE, 8'h00, 8'h00, 1'b0, -1, 0, 1'b0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // zero half period behaves as one
    set_config(1'b1, 8'd0, 8'd2);
    issue_command(i2cbm_pkg::CMD_START, 8'h00, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_SEND, 8'hFF, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_SEND, 8'hA5, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_RACK, 8'h00, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_RACK, 8'h00, 8'h00, 1'b1, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_RACK, 8'h00, 8'h00, 1'b0, -1, 2, 1'b0);
    issue_command(i2cbm_pkg::CMD_RACK, 8'h00, 8'h00, 1'b0, -1, 3, 1'b0);
    issue_command(i2cbm_pkg::CMD_READ, 8'h00, 8'hFF, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_READ, 8'h00, 8'h5A, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_ACK, 8'hFF, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_NACK, 8'h00, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_STOP, 8'h00, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_RESET, 8'h00, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_PROBE, 8'h42, 8'h00, 1'b0, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_PROBE, 8'hBD, 8'h00, 1'b1, -1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_PROBE, 8'h42, 8'h00, 1'b0, 0, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_PROBE, 8'h42, 8'h00, 1'b1, 12, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_START, 8'h00, 8'h00, 1'b0, 1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_STOP, 8'h00, 8'h00, 1'b0, 0, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_NACK, 8'h00, 8'h00, 1'b0, 1, 0, 1'b0);
    issue_command(i2cbm_pkg::CMD_PROBE + 4'd6, 8'h00, 8'h00, 1'b0, -1, 0, 1'b0);
    drain();

    set_config(1'b1, 8'd1, 8'd20);
    random_phase(4);
    drain();
    set_config(1'b1, 8'd2, 8'd0);
    random_phase(2);
    drain();
    set_config(1'b1, 8'd3, 8'd255);
    random_phase(1);
    drain();
    set_config(1'b0, 8'd4, 8'd5);
    random_phase(10);
    drain();
    set_config(1'b1, 8'd1, 8'd1);
    random_phase(3);
    drain();
    set_config(1'b1, 8'($urandom_range(8, 5)), 8'($urandom_range(255, 0)));
    random_phase(1);
    drain();
    repeat (8) @(posedge clk_i);

    $display("covered %0d ticks: ok %0d, nack %0d, mode error %0d, lost bus %0d, timeout %0d",
             ticks_seen, status_hits[i2cbm_pkg::STS_OK], status_hits[i2cbm_pkg::STS_NACK],
             status_hits[i2cbm_pkg::STS_MODE], status_hits[i2cbm_pkg::STS_LOST],
             status_hits[i2cbm_pkg::STS_TIMEOUT]);
    $display("half period 0..8, stretch limit 0..255, master on and off, %0d mismatches",
             mismatches);
    if (mismatches == 0 && bus_status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tick_q.size() > 0 && (calm || $urandom_range(99, 0) >= 27)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, tick_q.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: tick %0d %s mismatch, expected %0h, actual %0h",
               $time, ticks_seen, name, want, got);
      mismatches++;
    end
  endtask

  // result monitor, with one long hold-off to back the block up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res = m_axis_tdata[14:0];
        if (bus_status_q.size() == 0) begin
          $display("%0t: unexpected request, actual %0h", $time, got_res);
          mismatches++;
        end else begin
          want_res = bus_status_q.pop_front();
          check_field("scl_drive", int'(want_res.scl_drive), int'(got_res.scl_drive));
          check_field("sda_drive", int'(want_res.sda_drive), int'(got_res.sda_drive));
          check_field("busy", int'(want_res.busy_res), int'(got_res.busy_res));
          check_field("done", int'(want_res.done_res), int'(got_res.done_res));
          check_field("status", int'(want_res.status), int'(got_res.status));
          check_field("read_byte", int'(want_res.read_byte), int'(got_res.read_byte));
          if (want_res.done_res) status_hits[want_res.status]++;
        end
        ticks_seen++;
      end
      if (hold_cnt > 0) begin
        m_axis_tready <= 1'b0;
        hold_cnt      <= hold_cnt - 1;
      end else if (!hold_done && ticks_seen >= 200 && tick_q.size() > 50) begin
        m_axis_tready <= 1'b0;
        hold_cnt      <= HoldOff;
        hold_done     <= 1'b1;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99, 0) >= 27);
      end
    end
  end

  // cycle count and watchdog on cycles without any handshake
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc       <= 0;
      stall_cnt <= 0;
    end else begin
      cyc <= cyc + 1;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cnt);
        $display("tb: failure");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

endmodule

// ===== i2c_bit_level_master.f =====
sv/i2cbm_pkg.sv
sv/i2cbm_seq.sv
sv/i2cbm_obuf.sv
sv/i2c_bit_level_master.sv
tb/i2c_bit_level_master_tb.sv
